### hdl/bfr_pkg.sv
// Shared types and constants of the BLE module frame receiver.
`default_nettype none
package bfr_pkg;

    // Item commands
    localparam logic [1:0] CMD_RX_BYTE = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // Frame symbols and opcodes
    localparam logic [7:0] SYM_STX       = 8'h02;
    localparam logic [7:0] OP_DATA_IND   = 8'h84;
    localparam logic [7:0] OP_CONNECT    = 8'h86;
    localparam logic [7:0] OP_DISCONNECT = 8'h87;
    localparam logic [7:0] OP_OPEN_RSP   = 8'hC6;
    localparam logic [7:0] MIN_PACKET    = 8'd19;
    localparam int         PREFIX_LEN    = 7;
    localparam int         SIZE_BYTE     = 7;

    // Parser phases
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_CMD    = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;
    localparam logic [2:0] PH_CHECK  = 3'd5;

    // Frame events
    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_OK        = 2'd1;
    localparam logic [1:0] EV_BAD_CHECK = 2'd2;
    localparam logic [1:0] EV_TOO_LONG  = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture the accepted item
        logic exec;        // apply the item to the parser and flags
        logic copy_start;  // begin moving payload into the user buffer
        logic copy_step;   // advance the payload move
        logic emit;        // load the result register
    } bfr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic copy_needed;
        logic copy_done;
        logic out_busy;
    } bfr_status_t;

endpackage
`default_nettype wire

### hdl/bfr_ctrl.sv
// Controller state machine of the frame receiver.
`default_nettype none
module bfr_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic                 m_tready,
    input  wire bfr_pkg::bfr_status_t status,
    output bfr_pkg::bfr_cmd_t         cmd
);
    import bfr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_COPY = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;

    // Items are taken only while idle and the result slot is either empty or being emptied in this cycle.
    assign s_tready = aresetn && (state_reg == ST_IDLE) && (!status.out_busy || m_tready);

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (status.copy_needed) begin
                    cmd.copy_start = 1'b1;
                    state_next     = ST_COPY;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_COPY: begin
                cmd.copy_step = 1'b1;
                if (status.copy_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### hdl/bfr_datapath.sv
// Datapath of the frame receiver: parser registers, link flags, buffers, result register.
`default_nettype none
module bfr_datapath #(
    parameter int MAX_PAYLOAD = 128
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [1:0]           in_command,
    input  wire logic [7:0]           in_rx_byte,
    input  wire logic [6:0]           in_read_index,
    input  wire bfr_pkg::bfr_cmd_t    cmd,
    output bfr_pkg::bfr_status_t      status,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [31:0]               m_tdata
);
    import bfr_pkg::*;

    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam int PW = $clog2(MAX_PAYLOAD + 1);

    // Item registers
    logic [1:0]    cmd_reg;
    logic [7:0]    byte_reg;
    logic [6:0]    idx_reg;
    logic [7:0]    rd_reg;

    // Parser state
    logic [2:0]    phase_reg;
    logic [7:0]    fcmd_reg;
    logic [7:0]    len_lo_reg;
    logic [PW-1:0] flen_reg;
    logic [PW-1:0] pos_reg;
    logic [7:0]    check_reg;
    logic [7:0]    size_byte_reg;
    logic [1:0]    ev_reg;

    // Link state
    logic          conn_reg;
    logic          open_reg;
    logic [7:0]    size_reg;
    logic          ready_reg;
    logic [7:0]    count_reg;

    // Payload move
    logic [PW-1:0] cnt_reg;
    logic          wr_pend_reg;
    logic [AW-1:0] wr_addr_reg;
    logic [7:0]    fs_rd_reg;

    logic          out_valid_reg;
    logic [31:0]   out_data_reg;

    logic [7:0]    frame_store [MAX_PAYLOAD];
    logic [7:0]    user_store  [MAX_PAYLOAD];

    logic [15:0]   len_full;
    logic [PW:0]   pos_inc;
    logic [PW-1:0] copy_len;
    logic          rx_exec;
    logic          check_ok;
    logic          body_wr;
    logic          copy_rd;
    logic [7:0]    read_out;

    assign len_full = {byte_reg, len_lo_reg};
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;
    assign copy_len = flen_reg - PW'(PREFIX_LEN);
    assign rx_exec  = cmd.exec && (cmd_reg == CMD_RX_BYTE);
    assign check_ok = (phase_reg == PH_CHECK) && (byte_reg == check_reg);
    assign body_wr  = rx_exec && (phase_reg == PH_BODY);
    assign copy_rd  = cmd.copy_step && (cnt_reg < copy_len);

    assign status.copy_needed = rx_exec && check_ok && (fcmd_reg == OP_DATA_IND)
                              && !ready_reg && (flen_reg > PW'(PREFIX_LEN));
    assign status.copy_done   = (cnt_reg >= copy_len) && !wr_pend_reg;
    assign status.out_busy    = out_valid_reg;

    // Frame payload buffer: written by the parser, read by the payload move.
    always_ff @(posedge aclk) begin
        if (body_wr) begin
            frame_store[AW'(pos_reg)] <= byte_reg;
        end
        if (copy_rd) begin
            fs_rd_reg <= frame_store[AW'(cnt_reg + PW'(PREFIX_LEN))];
        end
    end

    // User data buffer: written by the payload move, read by the read command.
    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            user_store[wr_addr_reg] <= fs_rd_reg;
        end
        if (cmd.load) begin
            rd_reg <= user_store[AW'(in_read_index)];
        end
    end

    // Item capture and payload move bookkeeping carry no reset.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg  <= in_command;
            byte_reg <= in_rx_byte;
            idx_reg  <= in_read_index;
        end
        if (cmd.copy_start) begin
            cnt_reg <= '0;
        end else if (copy_rd) begin
            cnt_reg     <= cnt_reg + 1'b1;
            wr_addr_reg <= AW'(cnt_reg);
        end
        if (rx_exec && phase_reg == PH_BODY && pos_reg == PW'(SIZE_BYTE)) begin
            size_byte_reg <= byte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            fcmd_reg    <= '0;
            len_lo_reg  <= '0;
            flen_reg    <= '0;
            pos_reg     <= '0;
            check_reg   <= '0;
            ev_reg      <= EV_NONE;
            conn_reg    <= 1'b0;
            open_reg    <= 1'b0;
            size_reg    <= MIN_PACKET;
            ready_reg   <= 1'b0;
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
        end else begin
            wr_pend_reg <= copy_rd;
            if (cmd.exec) begin
                ev_reg <= EV_NONE;
                if (cmd_reg == CMD_RELEASE) begin
                    ready_reg <= 1'b0;
                end
            end
            if (rx_exec) begin
                unique case (phase_reg)
                    PH_START: begin
                        if (byte_reg == SYM_STX) begin
                            check_reg <= byte_reg;
                            phase_reg <= PH_CMD;
                        end
                    end
                    PH_CMD: begin
                        fcmd_reg  <= byte_reg;
                        check_reg <= check_reg ^ byte_reg;
                        phase_reg <= PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        len_lo_reg <= byte_reg;
                        check_reg  <= check_reg ^ byte_reg;
                        phase_reg  <= PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        check_reg <= check_reg ^ byte_reg;
                        pos_reg   <= '0;
                        flen_reg  <= PW'(len_full);
                        if (len_full > 16'(MAX_PAYLOAD)) begin
                            phase_reg <= PH_START;
                            ev_reg    <= EV_TOO_LONG;
                        end else if (len_full == 16'd0) begin
                            phase_reg <= PH_CHECK;
                        end else begin
                            phase_reg <= PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        pos_reg   <= pos_inc[PW-1:0];
                        check_reg <= check_reg ^ byte_reg;
                        if (pos_inc >= {1'b0, flen_reg}) begin
                            phase_reg <= PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        phase_reg <= PH_START;
                        if (check_ok) begin
                            ev_reg <= EV_OK;
                            case (fcmd_reg)
                                OP_CONNECT: begin
                                    conn_reg <= 1'b1;
                                    open_reg <= 1'b0;
                                end
                                OP_DISCONNECT: begin
                                    conn_reg <= 1'b0;
                                    open_reg <= 1'b0;
                                end
                                OP_OPEN_RSP: begin
                                    open_reg <= 1'b1;
                                    if (flen_reg >= PW'(SIZE_BYTE + 1)
                                        && size_byte_reg >= MIN_PACKET
                                        && 32'(size_byte_reg) <= MAX_PAYLOAD) begin
                                        size_reg <= size_byte_reg;
                                    end
                                end
                                default: ;
                            endcase
                        end else begin
                            ev_reg <= EV_BAD_CHECK;
                        end
                    end
                    default: phase_reg <= PH_START;
                endcase
            end
            // The move runs only after the check byte has matched a data indication.
            if (cmd.copy_start) begin
                ready_reg <= 1'b1;
                count_reg <= 8'(copy_len);
            end
        end
    end

    assign read_out = (cmd_reg == CMD_READ && 32'(idx_reg) < MAX_PAYLOAD) ? rd_reg : 8'd0;

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= {3'b000, read_out, ev_reg, count_reg, ready_reg,
                             size_reg, open_reg, conn_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

### hdl/ble_module_frame_receiver_unit.sv
// Top level of the BLE module frame receiver.
//
// The input channel carries one item per command: s_tuser selects receive
// byte, read user data or release user data; s_tdata holds the UART byte and
// the buffer read position. Every item gives exactly one result item on the
// output channel, showing the link flags, packet size, data status, the frame
// event of this item and the byte read from the user buffer.
// An ordinary item passes through capture, execution in the parser, and
// loading of the result register; the next item is taken only after its
// result has been loaded.
// A check byte that completes a data indication adds a byte-serial move of
// the payload into the user buffer, one byte a cycle through the registered
// read port of the frame buffer: the payload length minus 7 bytes.
// One item is in work at a time; a new one is taken once the result register
// is empty or being emptied.
// After reset the parser waits for a start byte, all flags are clear and
// the packet size is 19; the buffers hold nothing defined until written.
// When the receiver holds m_tready low, the result waits in its register and
// the input channel stalls after the current item.
`default_nettype none
module ble_module_frame_receiver_unit #(
    parameter int MAX_PAYLOAD = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // rx_byte[7:0], read_index[14:8], zero[15]
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // link_connected[0], channel_is_open[1],
                                        // packet_size[9:2], data_waiting[10],
                                        // data_count[18:11], frame_event[20:19],
                                        // read_data[28:21], zero[31:29]
);
    import bfr_pkg::*;

    bfr_cmd_t    cmd;
    bfr_status_t status;

    bfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bfr_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_command    (s_tuser),
        .in_rx_byte    (s_tdata[7:0]),
        .in_read_index (s_tdata[14:8]),
        .cmd           (cmd),
        .status        (status),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_tdata       (m_tdata)
    );

endmodule
`default_nettype wire
